// ===== rtl/sps_pkg.sv =====
// sps_pkg: shared types, codes and constants of the supply program sequencer
// depends on nothing; imported by every rtl module of the block
`default_nettype none

package sps_pkg;

  localparam int unsigned ProgramDepthDef = 32;
  localparam int unsigned StepW           = 6;
  localparam int unsigned ValueW          = 16;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpWrite = 2'd1,
    OpStart = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KindSetVolts       = 3'd0,
    KindSetAmps        = 3'd1,
    KindWaitAmpsAbove  = 3'd2,
    KindWaitAmpsBelow  = 3'd3,
    KindWaitVoltsAbove = 3'd4,
    KindWaitVoltsBelow = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ActNone     = 2'd0,
    ActSetVolts = 2'd1,
    ActSetAmps  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    StIdle,
    StDecode,
    StScan,
    StExec,
    StWaitRd,
    StWaitChk,
    StFinish
  } state_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [4:0]        entry_index;
    logic              entry_used;
    logic [2:0]        entry_kind;
    logic [ValueW-1:0] entry_value;
    logic [ValueW-1:0] millivolts;
    logic [ValueW-1:0] milliamps;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ValueW-1:0] action_value;
    logic              is_running;
    logic              is_waiting;
    logic [StepW-1:0]  current_step;
  } out_word_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [ValueW-1:0] value;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic do_write;
    logic start;
    logic ptr_inc;
    logic ptr_end;
    logic set_wait;
    logic clr_wait;
    logic set_act;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       running;
    logic       waiting;
    logic       ptr_in_range;
    logic       used_at_ptr;
    logic [2:0] kind;
    logic       wait_done;
    logic       out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/sps_datapath.sv =====
// sps_datapath: item register, program store, step pointer, flags and output register
// depends on sps_pkg; driven by sps_ctrl through dp_cmd_t
`default_nettype none

module sps_datapath #(
  parameter int unsigned PROGRAM_DEPTH = sps_pkg::ProgramDepthDef
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  sps_pkg::in_word_t    in_word_i,
  input  sps_pkg::dp_cmd_t     cmd_i,
  output sps_pkg::dp_status_t  status_o,
  input  wire                  out_stall_i,
  output logic                 out_valid_o,
  output sps_pkg::out_word_t   out_word_o
);
  import sps_pkg::*;

  localparam int unsigned AddrW = $clog2(PROGRAM_DEPTH);
  localparam int unsigned PtrW  = $clog2(PROGRAM_DEPTH + 1);

  in_word_t            item_q;
  logic [PtrW-1:0]     ptr_q, ptr_d;
  logic                running_q, running_d;
  logic                waiting_q, waiting_d;
  logic [PROGRAM_DEPTH-1:0] used_q;
  entry_t              mem_q [PROGRAM_DEPTH];
  entry_t              rd_q;
  logic [1:0]          act_q;
  logic [ValueW-1:0]   val_q;
  out_word_t           out_q;
  logic                out_valid_q;

  logic [AddrW-1:0]    ptr_addr;
  logic [AddrW-1:0]    wr_addr;
  logic                wr_in_range;
  logic                ptr_in_range;
  logic                wait_done;

  assign ptr_addr     = ptr_q[AddrW-1:0];
  assign wr_addr      = AddrW'(item_q.entry_index);
  assign wr_in_range  = 32'(item_q.entry_index) < 32'(PROGRAM_DEPTH);
  assign ptr_in_range = ptr_q < PtrW'(PROGRAM_DEPTH);

  always_comb begin
    unique case (kind_e'(rd_q.kind))
      KindWaitAmpsAbove:  wait_done = item_q.milliamps  >= rd_q.value;
      KindWaitAmpsBelow:  wait_done = item_q.milliamps  <= rd_q.value;
      KindWaitVoltsAbove: wait_done = item_q.millivolts >= rd_q.value;
      KindWaitVoltsBelow: wait_done = item_q.millivolts <= rd_q.value;
      default:            wait_done = 1'b1;
    endcase
  end

  always_comb begin
    status_o.op           = item_q.op;
    status_o.running      = running_q;
    status_o.waiting      = waiting_q;
    status_o.ptr_in_range = ptr_in_range;
    status_o.used_at_ptr  = ptr_in_range && used_q[ptr_addr];
    status_o.kind         = rd_q.kind;
    status_o.wait_done    = wait_done;
    status_o.out_busy     = out_valid_q && out_stall_i;
  end

  always_comb begin
    ptr_d     = ptr_q;
    running_d = running_q;
    waiting_d = waiting_q;
    if (cmd_i.start) begin
      ptr_d     = '0;
      running_d = 1'b1;
      waiting_d = 1'b0;
    end
    if (cmd_i.ptr_end) begin
      ptr_d     = PtrW'(PROGRAM_DEPTH);
      running_d = 1'b0;
    end
    if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + 1'b1;
    end
    if (cmd_i.set_wait) begin
      waiting_d = 1'b1;
    end
    if (cmd_i.clr_wait) begin
      waiting_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      running_q   <= 1'b0;
      waiting_q   <= 1'b0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q     <= ptr_d;
      running_q <= running_d;
      waiting_q <= waiting_d;
      if (cmd_i.do_write && wr_in_range) begin
        used_q[wr_addr] <= item_q.entry_used;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // program store, kind and value only; used flags live in used_q
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_write && wr_in_range) begin
      mem_q[wr_addr] <= '{kind: item_q.entry_kind, value: item_q.entry_value};
    end
    rd_q <= mem_q[ptr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_word_i;
      act_q  <= ActNone;
      val_q  <= '0;
    end else if (cmd_i.set_act) begin
      act_q <= (kind_e'(rd_q.kind) == KindSetVolts) ? ActSetVolts : ActSetAmps;
      val_q <= rd_q.value;
    end
    if (cmd_i.emit) begin
      out_q.action       <= act_q;
      out_q.action_value <= val_q;
      out_q.is_running   <= running_q;
      out_q.is_waiting   <= waiting_q;
      out_q.current_step <= StepW'(ptr_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_wait_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    waiting_q |-> running_q)
    else $error("waiting flag set while program not running");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PtrW'(PROGRAM_DEPTH))
    else $error("step pointer beyond end of program");

  a_inc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ptr_inc |-> ptr_in_range)
    else $error("step pointer advanced past end");

endmodule

`default_nettype wire

// ===== rtl/sps_ctrl.sv =====
// sps_ctrl: sequencing state machine of the supply program sequencer
// depends on sps_pkg; commands sps_datapath and reads its status
`default_nettype none

module sps_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  sps_pkg::dp_status_t  status_i,
  output sps_pkg::dp_cmd_t     cmd_o
);
  import sps_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StDecode;
      end
      StDecode: begin
        unique case (op_e'(status_i.op))
          OpStart: state_d = StScan;
          OpTick: begin
            if (!status_i.running)     state_d = StFinish;
            else if (status_i.waiting) state_d = StWaitRd;
            else                       state_d = StScan;
          end
          default: state_d = StFinish;
        endcase
      end
      StScan: begin
        if (!status_i.ptr_in_range)   state_d = StFinish;
        else if (status_i.used_at_ptr) state_d = StExec;
      end
      StExec: state_d = StFinish;
      StWaitRd: begin
        state_d = status_i.used_at_ptr ? StWaitChk : StFinish;
      end
      StWaitChk: state_d = StFinish;
      StFinish: begin
        if (!status_i.out_busy) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != StIdle);
    unique case (state_q)
      StIdle: cmd_o.load_item = in_valid_i;
      StDecode: begin
        unique case (op_e'(status_i.op))
          OpWrite: cmd_o.do_write = 1'b1;
          OpStart: cmd_o.start    = 1'b1;
          default: ;
        endcase
      end
      StScan: begin
        // skip unused slots one per cycle
        if (!status_i.ptr_in_range)    cmd_o.ptr_end = 1'b1;
        else if (!status_i.used_at_ptr) cmd_o.ptr_inc = 1'b1;
      end
      StExec: begin
        unique case (kind_e'(status_i.kind))
          KindSetVolts, KindSetAmps: begin
            cmd_o.set_act = 1'b1;
            cmd_o.ptr_inc = 1'b1;
          end
          KindWaitAmpsAbove, KindWaitAmpsBelow,
          KindWaitVoltsAbove, KindWaitVoltsBelow: cmd_o.set_wait = 1'b1;
          default: cmd_o.ptr_inc = 1'b1;
        endcase
      end
      StWaitRd: begin
        // wait slot gone or emptied: wait counts as done
        if (!status_i.used_at_ptr) begin
          cmd_o.clr_wait = 1'b1;
          cmd_o.ptr_inc  = status_i.ptr_in_range;
        end
      end
      StWaitChk: begin
        if (status_i.wait_done) begin
          cmd_o.clr_wait = 1'b1;
          cmd_o.ptr_inc  = 1'b1;
        end
      end
      StFinish: cmd_o.emit = !status_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_to_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_item |=> state_q == StDecode)
    else $error("accepted word not decoded next cycle");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !status_i.out_busy)
    else $error("result loaded over a stalled result");

  a_emit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> state_q == StIdle)
    else $error("controller not idle after result");

endmodule

`default_nettype wire

// ===== rtl/supply_program_sequencer_top.sv =====
// supply_program_sequencer_top: runs a stored power-supply program, one word at a time
// depends on sps_pkg, sps_ctrl and sps_datapath
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid_i / in_stall_o   | sps_pkg::in_word_t
//   out     | output    | out_valid_o / out_stall_i | sps_pkg::out_word_t
//
// one word is in work at a time; write, idle tick and unknown op pass decode and finish
// a start or a stepping tick scans unused slots, one program store read per cycle,
// then executes the used step if one is found; a wait check reads the slot, then checks it
// used flags reset at once with rst_ni, so there is no clearing pass
// a stalled result holds the block in its finish state until taken
`default_nettype none

module supply_program_sequencer_top #(
  parameter int unsigned PROGRAM_DEPTH = sps_pkg::ProgramDepthDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  sps_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output sps_pkg::out_word_t  out_word_o
);
  import sps_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  sps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sps_datapath #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
